>>> design/ftofh_pkg.sv
package ftofh_pkg;

    localparam int PIXELS = 16384;
    localparam int BINS = 64;
    localparam int PIX_W = $clog2(PIXELS);
    localparam int BIN_W = $clog2(BINS);
    localparam int CELL_W = PIX_W + BIN_W;
    localparam int CELLS = PIXELS * BINS;
    localparam int CNT_W = $clog2(PIXELS + 1);
    localparam int STEP_W = (BIN_W > 1) ? $clog2(BIN_W) : 1;
    localparam int W32 = 32;
    localparam logic [W32-1:0] RST_BIN_WIDTH = 32'd10000;

    typedef enum logic [1:0] {
        CMD_EVENT = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        CFG_TOF_MIN  = 3'd0,
        CFG_TOF_MAX  = 3'd1,
        CFG_BIN_W    = 3'd2,
        CFG_MIN_EVTS = 3'd3,
        CFG_MAX_EVTS = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic [1:0]  command;
        logic [13:0] pixel_index;
        logic [31:0] tof_ns;
        logic [5:0]  read_bin;
    } in_t;

    typedef struct packed {
        logic        frame_good;
        logic [31:0] frame_event_total;
        logic [31:0] raw_frame_total;
        logic [31:0] good_frame_total;
        logic [31:0] bin_count;
        logic        bin_dropped;
    } out_t;

    typedef struct packed {
        logic take_item;
        logic clr_step;
        logic ev_check;
        logic div_first;
        logic div_step;
        logic ev_read;
        logic ev_write;
        logic rd_read;
        logic fr_eval;
        logic cl_list_read;
        logic cl_pix;
        logic cl_read;
        logic cl_write;
        logic fr_done;
        logic res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_range;
        logic drop_now;
        logic div_last;
        logic list_empty;
        logic bin_last;
        logic pix_last;
    } dp_stat_t;

endpackage

>>> design/ftofh_dp.sv
module ftofh_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  ftofh_pkg::in_t           in_data,
    input  ftofh_pkg::dp_cmd_t       cmd,
    output ftofh_pkg::dp_stat_t      stat,
    output ftofh_pkg::out_t          res
);

    localparam int PW = ftofh_pkg::PIX_W;
    localparam int BW = ftofh_pkg::BIN_W;
    localparam int CW = ftofh_pkg::CELL_W;
    localparam int NW = ftofh_pkg::CNT_W;
    localparam int SW = ftofh_pkg::STEP_W;
    localparam int XW = 32 + BW;

    logic [31:0] tmin_reg, tmax_reg, bwid_reg, emin_reg, emax_reg;
    logic [31:0] fev_reg, raw_reg, gcnt_reg, nsnap_reg;
    logic        good_reg;
    logic [NW-1:0] lcnt_reg, walk_k_reg;
    logic [CW-1:0] clr_reg;

    ftofh_pkg::in_t item_reg;
    logic [31:0]   rem_reg, wid_reg;
    logic [BW-1:0] quo_reg, walk_b_reg;
    logic [SW-1:0] step_reg;
    logic          in_range_reg, drop_reg;
    logic [PW-1:0] pix_reg;
    ftofh_pkg::out_t res_reg;
    ftofh_pkg::out_t res_next;

    logic [31:0]   main_mem [ftofh_pkg::CELLS];
    logic [15:0]   frame_mem [ftofh_pkg::CELLS];
    logic          flag_mem [ftofh_pkg::PIXELS];
    logic [PW-1:0] list_mem [ftofh_pkg::PIXELS];
    logic [31:0]   main_q;
    logic [15:0]   frame_q;
    logic          flag_q;
    logic [PW-1:0] list_q;

    logic          main_we, main_re, frame_we, frame_re, flag_we;
    logic [CW-1:0] main_wa, main_ra, frame_a;
    logic [31:0]   main_wd;
    logic [15:0]   frame_wd;
    logic [PW-1:0] flag_a;
    logic          flag_wd;

    logic [CW-1:0] ev_addr, walk_addr, rd_addr;
    logic          rd_ok, pix_bad, big, fgood;
    logic [XW-1:0] shifted;
    logic [32:0]   msum;
    logic [31:0]   msat;
    logic [16:0]   finc;

    assign ev_addr = {item_reg.pixel_index[PW-1:0], quo_reg};
    assign walk_addr = {pix_reg, walk_b_reg};
    assign rd_addr = {item_reg.pixel_index[PW-1:0], item_reg.read_bin[BW-1:0]};
    assign rd_ok = ({3'b000, item_reg.pixel_index} < 17'(ftofh_pkg::PIXELS))
        && ({7'b0, item_reg.read_bin} < 13'(ftofh_pkg::BINS));
    assign pix_bad = {3'b000, item_reg.pixel_index} >= 17'(ftofh_pkg::PIXELS);
    assign big = {{BW{1'b0}}, rem_reg} >= {wid_reg, {BW{1'b0}}};
    assign shifted = {{BW{1'b0}}, wid_reg} << (SW'(BW - 1) - step_reg);
    assign msum = {1'b0, main_q} + {17'b0, frame_q};
    assign msat = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
    assign finc = {1'b0, frame_q} + 17'd1;
    assign fgood = (fev_reg >= emin_reg) && (fev_reg <= emax_reg);

    assign stat.clr_done = (clr_reg == CW'(ftofh_pkg::CELLS - 1));
    assign stat.in_range = in_range_reg;
    assign stat.drop_now = in_range_reg && (big || pix_bad);
    assign stat.div_last = (step_reg == SW'(BW - 1));
    assign stat.list_empty = (lcnt_reg == '0);
    assign stat.bin_last = (walk_b_reg == BW'(ftofh_pkg::BINS - 1));
    assign stat.pix_last = ((walk_k_reg + NW'(1)) == lcnt_reg);
    assign res = res_reg;

    always_comb
    begin
        main_we = 1'b0;
        main_wa = walk_addr;
        main_wd = msat;
        main_re = 1'b0;
        main_ra = walk_addr;
        frame_we = 1'b0;
        frame_re = 1'b0;
        frame_a = walk_addr;
        frame_wd = '0;
        flag_we = 1'b0;
        flag_a = item_reg.pixel_index[PW-1:0];
        flag_wd = 1'b0;
        if (cmd.clr_step)
        begin
            main_we = 1'b1;
            main_wa = clr_reg;
            main_wd = '0;
            frame_we = 1'b1;
            frame_a = clr_reg;
            flag_we = (clr_reg[CW-1:PW] == '0);
            flag_a = clr_reg[PW-1:0];
        end
        if (cmd.ev_read)
        begin
            frame_re = 1'b1;
            frame_a = ev_addr;
        end
        if (cmd.ev_write)
        begin
            frame_we = 1'b1;
            frame_a = ev_addr;
            frame_wd = finc[16] ? frame_q : finc[15:0];
            flag_we = !flag_q;
            flag_wd = 1'b1;
        end
        if (cmd.rd_read)
        begin
            main_re = rd_ok;
            main_ra = rd_addr;
        end
        if (cmd.cl_pix)
        begin
            flag_we = 1'b1;
            flag_a = list_q;
        end
        if (cmd.cl_read)
        begin
            main_re = 1'b1;
            frame_re = 1'b1;
        end
        if (cmd.cl_write)
        begin
            main_we = good_reg;
            frame_we = 1'b1;
        end
    end

    always_comb
    begin
        res_next = '0;
        case (ftofh_pkg::cmd_e'(item_reg.command))
            ftofh_pkg::CMD_EVENT:
            begin
                res_next.bin_dropped = drop_reg && in_range_reg;
            end
            ftofh_pkg::CMD_FRAME:
            begin
                res_next.frame_good = good_reg;
                res_next.frame_event_total = nsnap_reg;
                res_next.raw_frame_total = raw_reg;
                res_next.good_frame_total = gcnt_reg;
            end
            ftofh_pkg::CMD_READ:
            begin
                res_next.bin_count = rd_ok ? main_q : 32'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (main_we)
        begin
            main_mem[main_wa] <= main_wd;
        end
        if (main_re)
        begin
            main_q <= main_mem[main_ra];
        end
        if (frame_we)
        begin
            frame_mem[frame_a] <= frame_wd;
        end
        if (frame_re)
        begin
            frame_q <= frame_mem[frame_a];
        end
        if (flag_we)
        begin
            flag_mem[flag_a] <= flag_wd;
        end
        if (cmd.ev_read)
        begin
            flag_q <= flag_mem[flag_a];
        end
        if (cmd.ev_write && !flag_q)
        begin
            list_mem[lcnt_reg[PW-1:0]] <= item_reg.pixel_index[PW-1:0];
        end
        if (cmd.cl_list_read)
        begin
            list_q <= list_mem[walk_k_reg[PW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmin_reg <= '0;
            tmax_reg <= 32'hFFFF_FFFF;
            bwid_reg <= ftofh_pkg::RST_BIN_WIDTH;
            emin_reg <= '0;
            emax_reg <= 32'hFFFF_FFFF;
            fev_reg <= '0;
            raw_reg <= '0;
            gcnt_reg <= '0;
            lcnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (ftofh_pkg::cfg_idx_e'(cfg_index))
                    ftofh_pkg::CFG_TOF_MIN:  tmin_reg <= cfg_data;
                    ftofh_pkg::CFG_TOF_MAX:  tmax_reg <= cfg_data;
                    ftofh_pkg::CFG_BIN_W:    bwid_reg <= cfg_data;
                    ftofh_pkg::CFG_MIN_EVTS: emin_reg <= cfg_data;
                    ftofh_pkg::CFG_MAX_EVTS: emax_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clr_step && !stat.clr_done)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cmd.ev_check && (fev_reg != 32'hFFFF_FFFF))
            begin
                fev_reg <= fev_reg + 32'd1;
            end
            if (cmd.ev_write && !flag_q)
            begin
                lcnt_reg <= lcnt_reg + NW'(1);
            end
            if (cmd.fr_eval)
            begin
                fev_reg <= '0;
                if (raw_reg != 32'hFFFF_FFFF)
                begin
                    raw_reg <= raw_reg + 32'd1;
                end
                if (fgood && (gcnt_reg != 32'hFFFF_FFFF))
                begin
                    gcnt_reg <= gcnt_reg + 32'd1;
                end
            end
            if (cmd.fr_done)
            begin
                lcnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.ev_check)
        begin
            in_range_reg <= (item_reg.tof_ns >= tmin_reg) && (item_reg.tof_ns < tmax_reg);
            rem_reg <= item_reg.tof_ns - tmin_reg;
            wid_reg <= (bwid_reg == '0) ? 32'd1 : bwid_reg;
        end
        if (cmd.div_first)
        begin
            drop_reg <= stat.drop_now;
            quo_reg <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if ({{BW{1'b0}}, rem_reg} >= shifted)
            begin
                rem_reg <= rem_reg - shifted[31:0];
                quo_reg <= {quo_reg[BW-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[BW-2:0], 1'b0};
            end
            step_reg <= step_reg + SW'(1);
        end
        if (cmd.fr_eval)
        begin
            good_reg <= fgood;
            nsnap_reg <= fev_reg;
            walk_k_reg <= '0;
        end
        if (cmd.cl_pix)
        begin
            pix_reg <= list_q;
            walk_b_reg <= '0;
        end
        if (cmd.cl_write)
        begin
            walk_b_reg <= walk_b_reg + BW'(1);
            if (stat.bin_last)
            begin
                walk_k_reg <= walk_k_reg + NW'(1);
            end
        end
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> design/ftofh_ctrl.sv
module ftofh_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [1:0]               in_command,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  ftofh_pkg::dp_stat_t      stat,
    output ftofh_pkg::dp_cmd_t       cmd
);

    typedef enum logic [14:0] {
        ST_CLEAR   = 15'b000000000000001,
        ST_IDLE    = 15'b000000000000010,
        ST_EV_CHK  = 15'b000000000000100,
        ST_DIV0    = 15'b000000000001000,
        ST_DIV     = 15'b000000000010000,
        ST_EV_RD   = 15'b000000000100000,
        ST_EV_WR   = 15'b000000001000000,
        ST_RD_MEM  = 15'b000000010000000,
        ST_FR_EVAL = 15'b000000100000000,
        ST_CL_LIST = 15'b000001000000000,
        ST_CL_PIX  = 15'b000010000000000,
        ST_CL_RD   = 15'b000100000000000,
        ST_CL_WR   = 15'b001000000000000,
        ST_FR_DONE = 15'b010000000000000,
        ST_EMIT    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    case (ftofh_pkg::cmd_e'(in_command))
                        ftofh_pkg::CMD_EVENT: state_next = ST_EV_CHK;
                        ftofh_pkg::CMD_FRAME: state_next = ST_FR_EVAL;
                        ftofh_pkg::CMD_READ:  state_next = ST_RD_MEM;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EV_CHK:
            begin
                cmd.ev_check = 1'b1;
                state_next = ST_DIV0;
            end
            ST_DIV0:
            begin
                cmd.div_first = 1'b1;
                if (!stat.in_range || stat.drop_now)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_EV_RD;
                end
            end
            ST_EV_RD:
            begin
                cmd.ev_read = 1'b1;
                state_next = ST_EV_WR;
            end
            ST_EV_WR:
            begin
                cmd.ev_write = 1'b1;
                state_next = ST_EMIT;
            end
            ST_RD_MEM:
            begin
                cmd.rd_read = 1'b1;
                state_next = ST_EMIT;
            end
            ST_FR_EVAL:
            begin
                cmd.fr_eval = 1'b1;
                state_next = stat.list_empty ? ST_FR_DONE : ST_CL_LIST;
            end
            ST_CL_LIST:
            begin
                cmd.cl_list_read = 1'b1;
                state_next = ST_CL_PIX;
            end
            ST_CL_PIX:
            begin
                cmd.cl_pix = 1'b1;
                state_next = ST_CL_RD;
            end
            ST_CL_RD:
            begin
                cmd.cl_read = 1'b1;
                state_next = ST_CL_WR;
            end
            ST_CL_WR:
            begin
                cmd.cl_write = 1'b1;
                if (!stat.bin_last)
                begin
                    state_next = ST_CL_RD;
                end
                else if (stat.pix_last)
                begin
                    state_next = ST_FR_DONE;
                end
                else
                begin
                    state_next = ST_CL_LIST;
                end
            end
            ST_FR_DONE:
            begin
                cmd.fr_done = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/frame_vetoed_tof_histogrammer.sv
// After reset the block sweeps all 1048576 cells of both histogram stores to zero, one
// cell per cycle; during the sweep no input transaction is taken, while register writes
// are taken at any time. An event passes through the six-step bin divider and the
// read-modify-write of one frame cell; an event that is out of range or past the bin
// store skips both. A frame start merges each hit pixel row into the main store, when
// the frame is good, and clears it in the frame store, cell by cell with a read state
// and a write state per cell. A finished result is held in an output register, so the
// next input transaction is taken while the previous result waits; the next result is
// loaded only once the previous one is taken.
module frame_vetoed_tof_histogrammer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ftofh_pkg::in_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ftofh_pkg::out_t      out_data
);

    ftofh_pkg::dp_cmd_t  cmd;
    ftofh_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ftofh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    ftofh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .res       (out_data)
    );

endmodule
